[rtl/core/rmp_pkg.sv]
// ----------------------------------------------------------------------------
// rmp_pkg: shared types and constants for the RTTTL melody parser
// Parse phases, controller states, the command/status structs between the
// controller and the datapath, and the note frequency table.
// ----------------------------------------------------------------------------
package rmp_pkg;

   // Register reset values and limits
   localparam logic [5:0] DEF_DURATION_RST = 6'd4;
   localparam logic [2:0] DEF_OCTAVE_RST   = 3'd6;
   localparam logic [9:0] DEF_TEMPO_RST    = 10'd63;
   localparam logic [9:0] FALLBACK_TEMPO   = 10'd63;
   localparam int         OCTAVE_OFFSET_DEF    = 0;
   localparam int         NOTE_TABLE_DEPTH_DEF = 49;
   localparam int         PITCH_ROM_DEPTH      = 49;

   // Register indexes
   localparam logic [1:0] REG_DURATION = 2'd0;
   localparam logic [1:0] REG_OCTAVE   = 2'd1;
   localparam logic [1:0] REG_TEMPO    = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LC    = 8'h63;
   localparam logic [7:0] CH_LD    = 8'h64;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LO    = 8'h6F;

   // 60 s in ms, dividend of the whole-note time
   localparam logic [17:0] MINUTE_MS = 18'd60000;

   // Restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = 18;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [15:0] {
      PH_NAME         = 16'h0001,
      PH_HDR_D        = 16'h0002,
      PH_D_SKIP       = 16'h0004,
      PH_D_NUM        = 16'h0008,
      PH_HDR_O        = 16'h0010,
      PH_O_SKIP       = 16'h0020,
      PH_O_DIGIT      = 16'h0040,
      PH_O_COMMA      = 16'h0080,
      PH_HDR_B        = 16'h0100,
      PH_B_SKIP       = 16'h0200,
      PH_B_NUM        = 16'h0400,
      PH_NOTE         = 16'h0800,
      PH_AFTER_LETTER = 16'h1000,
      PH_AFTER_SHARP  = 16'h2000,
      PH_AFTER_DOT    = 16'h4000,
      PH_AFTER_OCT    = 16'h8000
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // input transfer this cycle
      logic set_tempo;  // write divider quotient into whole-note time
      logic load_out;   // load result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;   // current byte starts a division
      logic is_emit;    // division in flight belongs to a note result
      logic div_done;   // divider idle / finished
      logic div_busy;   // divider iterating
   } status_type;

   // Note frequency table: pause, then C4..B7
   function automatic logic [11:0] pitch_hz(input logic [5:0] k);
      logic [11:0] f;
      case (k)
         6'd1:  f = 12'd262;  6'd2:  f = 12'd277;  6'd3:  f = 12'd294;
         6'd4:  f = 12'd311;  6'd5:  f = 12'd330;  6'd6:  f = 12'd349;
         6'd7:  f = 12'd370;  6'd8:  f = 12'd392;  6'd9:  f = 12'd415;
         6'd10: f = 12'd440;  6'd11: f = 12'd466;  6'd12: f = 12'd494;
         6'd13: f = 12'd523;  6'd14: f = 12'd554;  6'd15: f = 12'd587;
         6'd16: f = 12'd622;  6'd17: f = 12'd659;  6'd18: f = 12'd698;
         6'd19: f = 12'd740;  6'd20: f = 12'd784;  6'd21: f = 12'd831;
         6'd22: f = 12'd880;  6'd23: f = 12'd932;  6'd24: f = 12'd988;
         6'd25: f = 12'd1047; 6'd26: f = 12'd1109; 6'd27: f = 12'd1175;
         6'd28: f = 12'd1245; 6'd29: f = 12'd1319; 6'd30: f = 12'd1397;
         6'd31: f = 12'd1480; 6'd32: f = 12'd1568; 6'd33: f = 12'd1661;
         6'd34: f = 12'd1760; 6'd35: f = 12'd1865; 6'd36: f = 12'd1976;
         6'd37: f = 12'd2093; 6'd38: f = 12'd2217; 6'd39: f = 12'd2349;
         6'd40: f = 12'd2489; 6'd41: f = 12'd2637; 6'd42: f = 12'd2794;
         6'd43: f = 12'd2960; 6'd44: f = 12'd3136; 6'd45: f = 12'd3322;
         6'd46: f = 12'd3520; 6'd47: f = 12'd3729; 6'd48: f = 12'd3951;
         default: f = 12'd0;
      endcase
      return f;
   endfunction

endpackage

[rtl/core/rtttl_melody_parser.sv]
// ----------------------------------------------------------------------------
// rtttl_melody_parser: RTTTL ringtone text to note stream
// Top level: control registers, controller and datapath.
// ----------------------------------------------------------------------------
// The block takes an RTTTL tune one byte per transfer and returns one note
// (semitone index, frequency, length in ms, octave error, end of tune) each
// time a note closes at a comma, a following note byte, or a zero byte.
// Bytes that close no note and set no tempo need no division. A byte that
// closes a note, the ':' that starts a tune and the byte that ends the b=
// field run the shared restoring divider, one quotient bit per cycle. The
// note or the new whole-note time lands in its register once the divider
// is done, and the next byte can be taken in the cycle after, so such a
// byte holds off the input until then. The result register lets the next
// byte be taken while a note waits on the result channel.
module rtttl_melody_parser #(
   parameter int OCTAVE_OFFSET    = rmp_pkg::OCTAVE_OFFSET_DEF,
   parameter int NOTE_TABLE_DEPTH = rmp_pkg::NOTE_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_tune_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_semitone_index,
   output logic [11:0] rsp_frequency_hz,
   output logic [18:0] rsp_duration_ms,
   output logic        rsp_octave_error,
   output logic        rsp_end_of_tune,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rmp_pkg::*;

   logic [5:0] dur_ff;
   logic [2:0] oct_ff;
   logic [9:0] tempo_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;
   cmd_type    cmd;
   status_type st;

   // control registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff   <= DEF_DURATION_RST;
         oct_ff   <= DEF_OCTAVE_RST;
         tempo_ff <= DEF_TEMPO_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_DURATION: dur_ff   <= csr_pwdata[5:0];
            REG_OCTAVE:   oct_ff   <= csr_pwdata[2:0];
            REG_TEMPO:    tempo_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_DURATION: csr_prdata = 32'(dur_ff);
         REG_OCTAVE:   csr_prdata = 32'(oct_ff);
         REG_TEMPO:    csr_prdata = 32'(tempo_ff);
         default:      csr_prdata = '0;
      endcase
   end

   rmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   rmp_dpath #(
      .OCTAVE_OFFSET    (OCTAVE_OFFSET),
      .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .cfg_duration       (dur_ff),
      .cfg_octave         (oct_ff),
      .cfg_tempo          (tempo_ff),
      .req_tune_byte      (req_tune_byte),
      .rsp_semitone_index (rsp_semitone_index),
      .rsp_frequency_hz   (rsp_frequency_hz),
      .rsp_duration_ms    (rsp_duration_ms),
      .rsp_octave_error   (rsp_octave_error),
      .rsp_end_of_tune    (rsp_end_of_tune)
   );

   // no byte is taken while the divider iterates
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      st.div_busy |-> !req_ready)
      else $error("byte accepted during division");

   // a division only starts from an input transfer
   a_div_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(st.div_busy) |-> $past(req_valid && req_ready))
      else $error("division started without a transfer");

   // out-of-table notes come out as a silent pause
   a_err_is_pause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_octave_error) |->
         (rsp_semitone_index == 6'd0 && rsp_frequency_hz == 12'd0))
      else $error("octave error with nonzero pitch");

   // a pause never carries a frequency
   a_pause_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_semitone_index == 6'd0) |-> (rsp_frequency_hz == 12'd0))
      else $error("pause with nonzero frequency");

endmodule

[rtl/core/rmp_ctrl.sv]
// ----------------------------------------------------------------------------
// rmp_ctrl: sequencing controller
// Accepts bytes, waits out divisions, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rmp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rmp_pkg::status_type st,
   output rmp_pkg::cmd_type    cmd
);
   import rmp_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (st.need_div) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (st.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!st.is_emit) begin
               cmd.set_tempo = 1'b1;
               state_in      = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/rmp_dpath.sv]
// ----------------------------------------------------------------------------
// rmp_dpath: parser datapath
// Byte decoder and parse registers, note index lookup, shared iterative
// divider, and the result register.
// ----------------------------------------------------------------------------
module rmp_dpath #(
   parameter int OCTAVE_OFFSET    = rmp_pkg::OCTAVE_OFFSET_DEF,
   parameter int NOTE_TABLE_DEPTH = rmp_pkg::NOTE_TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rmp_pkg::cmd_type    cmd,
   output rmp_pkg::status_type st,
   input  logic [5:0]          cfg_duration,
   input  logic [2:0]          cfg_octave,
   input  logic [9:0]          cfg_tempo,
   input  logic [7:0]          req_tune_byte,
   output logic [5:0]          rsp_semitone_index,
   output logic [11:0]         rsp_frequency_hz,
   output logic [18:0]         rsp_duration_ms,
   output logic                rsp_octave_error,
   output logic                rsp_end_of_tune
);
   import rmp_pkg::*;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [5:0]  tdur_ff, tdur_in;
   logic [2:0]  toct_ff, toct_in;
   logic [17:0] whole_ff, whole_in;
   logic [3:0]  code_ff, code_in;
   logic        dot_ff, dot_in;
   logic [3:0]  poct_ff, poct_in;
   logic        pend_ff, pend_in;

   // byte decode
   logic [7:0]  c;
   logic        c_digit;
   logic        ft_o, ft_b, ft_note, ft_sharp, ft_dot, ft_oct;
   logic        emit_c, end_c, tempo_c;
   logic [15:0] tempo_bpm, bpm_r;
   logic [3:0]  letter_code;

   // emit snapshot
   logic [15:0] note_div;
   logic [4:0]  scale;
   logic [7:0]  k;
   logic        k_ok;
   logic        emit_ff, end_ff, spend_ff, sdot_ff, serr_ff;
   logic [5:0]  sidx_ff;
   logic [11:0] sfreq_ff;

   // divider
   logic [15:0]          dvs_ff;
   logic [15:0]          rem_ff;
   logic [17:0]          dvd_ff;
   logic [17:0]          quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [15:0]          dvs_c;
   logic [17:0]          dvd_c;
   logic [16:0]          rem_sh;
   logic                 q_bit;
   logic [18:0]          dur_c;

   // result register
   logic [5:0]  out_idx_ff;
   logic [11:0] out_freq_ff;
   logic [18:0] out_dur_ff;
   logic        out_err_ff, out_end_ff;

   function automatic logic [15:0] acc_push(input logic [15:0] a, input logic [3:0] d);
      logic [19:0] v;
      v = (20'(a) << 3) + (20'(a) << 1) + 20'(d);
      return (v > 20'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   assign c       = req_tune_byte;
   assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);

   // note letter to semitone code
   always_comb begin
      case (c)
         CH_LC:   letter_code = 4'd1;
         CH_LD:   letter_code = 4'd3;
         CH_LE:   letter_code = 4'd5;
         CH_LF:   letter_code = 4'd6;
         CH_LG:   letter_code = 4'd8;
         CH_LA:   letter_code = 4'd10;
         CH_LB:   letter_code = 4'd12;
         default: letter_code = 4'd0;
      endcase
   end

   // parse step for one byte; header and note fields fall through in order
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      tdur_in   = tdur_ff;
      toct_in   = toct_ff;
      code_in   = code_ff;
      dot_in    = dot_ff;
      poct_in   = poct_ff;
      pend_in   = pend_ff;
      ft_o      = 1'b0;
      ft_b      = 1'b0;
      ft_note   = 1'b0;
      ft_sharp  = 1'b0;
      ft_dot    = 1'b0;
      ft_oct    = 1'b0;
      emit_c    = 1'b0;
      end_c     = 1'b0;
      tempo_c   = 1'b0;
      tempo_bpm = acc_ff;
      if (c == CH_NUL) begin
         emit_c   = 1'b1;
         end_c    = 1'b1;
         acc_in   = '0;
         code_in  = '0;
         dot_in   = 1'b0;
         poct_in  = '0;
         pend_in  = 1'b0;
         phase_in = PH_NAME;
      end else begin
         unique case (phase_ff)
            PH_NAME: begin
               if (c == CH_COLON) begin
                  tdur_in   = cfg_duration;
                  toct_in   = cfg_octave;
                  tempo_c   = 1'b1;
                  tempo_bpm = 16'(cfg_tempo);
                  acc_in    = '0;
                  code_in   = '0;
                  dot_in    = 1'b0;
                  poct_in   = '0;
                  pend_in   = 1'b0;
                  phase_in  = PH_HDR_D;
               end
            end
            PH_D_SKIP: phase_in = PH_D_NUM;
            PH_D_NUM: begin
               if (c_digit) begin
                  acc_in = acc_push(acc_ff, c[3:0]);
               end else begin
                  if (acc_ff != 16'd0) begin
                     tdur_in = (acc_ff > 16'd63) ? 6'd63 : acc_ff[5:0];
                  end
                  acc_in   = '0;
                  phase_in = PH_HDR_O;
               end
            end
            PH_O_SKIP: phase_in = PH_O_DIGIT;
            PH_O_DIGIT: begin
               if ((c >= CH_THREE) && (c <= CH_SEVEN)) begin
                  toct_in = c[2:0];
               end
               phase_in = PH_O_COMMA;
            end
            PH_O_COMMA: phase_in = PH_HDR_B;
            PH_B_SKIP:  phase_in = PH_B_NUM;
            PH_B_NUM: begin
               if (c_digit) begin
                  acc_in = acc_push(acc_ff, c[3:0]);
               end else begin
                  tempo_c   = 1'b1;
                  tempo_bpm = acc_ff;
                  acc_in    = '0;
                  phase_in  = PH_NOTE;
               end
            end
            PH_HDR_D: begin
               if (c == CH_LD) begin
                  phase_in = PH_D_SKIP;
               end else begin
                  ft_o = 1'b1;
               end
            end
            PH_HDR_O:        ft_o     = 1'b1;
            PH_HDR_B:        ft_b     = 1'b1;
            PH_NOTE:         ft_note  = 1'b1;
            PH_AFTER_LETTER: ft_sharp = 1'b1;
            PH_AFTER_SHARP:  ft_dot   = 1'b1;
            PH_AFTER_DOT:    ft_oct   = 1'b1;
            PH_AFTER_OCT:    emit_c   = 1'b1;
            default: ;
         endcase
         if (ft_o) begin
            if (c == CH_LO) begin
               phase_in = PH_O_SKIP;
            end else begin
               ft_b = 1'b1;
            end
         end
         if (ft_b) begin
            if (c == CH_LB) begin
               phase_in = PH_B_SKIP;
            end else begin
               ft_note = 1'b1;
            end
         end
         if (ft_sharp) begin
            if (c == CH_SHARP) begin
               code_in  = code_ff + 4'd1;
               phase_in = PH_AFTER_SHARP;
            end else begin
               ft_dot = 1'b1;
            end
         end
         if (ft_dot) begin
            if (c == CH_DOT) begin
               dot_in   = 1'b1;
               phase_in = PH_AFTER_DOT;
            end else begin
               ft_oct = 1'b1;
            end
         end
         if (ft_oct) begin
            if (c_digit) begin
               poct_in  = c[3:0] + 4'd1;
               phase_in = PH_AFTER_OCT;
            end else begin
               emit_c = 1'b1;
            end
         end
         // note ends: clear it, then the byte starts the next note unless a comma
         if (emit_c) begin
            acc_in   = '0;
            code_in  = '0;
            dot_in   = 1'b0;
            poct_in  = '0;
            pend_in  = 1'b0;
            phase_in = PH_NOTE;
            if (c != CH_COMMA) begin
               ft_note = 1'b1;
            end
         end
         if (ft_note) begin
            if (c_digit) begin
               acc_in   = acc_push(acc_in, c[3:0]);
               phase_in = PH_NOTE;
            end else begin
               code_in  = letter_code;
               pend_in  = 1'b1;
               phase_in = PH_AFTER_LETTER;
            end
         end
      end
   end

   // tempo fallback chain: header value, then register, then fixed
   always_comb begin
      if (tempo_bpm != 16'd0) begin
         bpm_r = tempo_bpm;
      end else if (cfg_tempo != 10'd0) begin
         bpm_r = 16'(cfg_tempo);
      end else begin
         bpm_r = 16'(FALLBACK_TEMPO);
      end
   end

   // note length divisor and table index of the note being closed
   always_comb begin
      if (acc_ff != 16'd0) begin
         note_div = acc_ff;
      end else if (tdur_ff != 6'd0) begin
         note_div = 16'(tdur_ff);
      end else begin
         note_div = 16'd1;
      end
      scale = ((poct_ff != 4'd0) ? 5'(poct_ff - 4'd1) : 5'(toct_ff)) + 5'(OCTAVE_OFFSET);
      k     = 8'(5'(scale - 5'd4) * 8'd12) + 8'(code_ff);
      k_ok  = (scale >= 5'd4) && (32'(k) < NOTE_TABLE_DEPTH) && (32'(k) < PITCH_ROM_DEPTH);
   end

   assign dvs_c = tempo_c ? bpm_r : note_div;
   assign dvd_c = tempo_c ? MINUTE_MS : whole_ff;

   // one restoring step
   assign rem_sh = {rem_ff, dvd_ff[17]};
   assign q_bit  = (rem_sh >= {1'b0, dvs_ff});

   assign dur_c  = spend_ff ? (19'(quo_ff) + (sdot_ff ? 19'(quo_ff >> 1) : 19'd0)) : 19'd0;

   assign whole_in = cmd.set_tempo ? {quo_ff[15:0], 2'b00} : whole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         acc_ff   <= '0;
         tdur_ff  <= DEF_DURATION_RST;
         toct_ff  <= DEF_OCTAVE_RST;
         whole_ff <= '0;
         code_ff  <= '0;
         dot_ff   <= 1'b0;
         poct_ff  <= '0;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         whole_ff <= whole_in;
         if (cmd.accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            tdur_ff  <= tdur_in;
            toct_ff  <= toct_in;
            code_ff  <= code_in;
            dot_ff   <= dot_in;
            poct_ff  <= poct_in;
            pend_ff  <= pend_in;
            emit_ff  <= emit_c;
         end
         if (cmd.accept && (emit_c || tempo_c)) begin
            cnt_ff <= DIV_CNT_W'(DIV_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // snapshot of the closing note and divider datapath
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         end_ff   <= end_c;
         spend_ff <= pend_ff;
         sdot_ff  <= dot_ff;
         sidx_ff  <= (code_ff != 4'd0 && k_ok) ? k[5:0] : 6'd0;
         sfreq_ff <= (code_ff != 4'd0 && k_ok) ? pitch_hz(k[5:0]) : 12'd0;
         serr_ff  <= pend_ff && (code_ff != 4'd0) && !k_ok;
         dvs_ff   <= dvs_c;
         dvd_ff   <= dvd_c;
         rem_ff   <= '0;
         quo_ff   <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= q_bit ? 16'(rem_sh - {1'b0, dvs_ff}) : rem_sh[15:0];
         quo_ff <= {quo_ff[16:0], q_bit};
         dvd_ff <= {dvd_ff[16:0], 1'b0};
      end
      if (cmd.load_out) begin
         out_idx_ff  <= sidx_ff;
         out_freq_ff <= sfreq_ff;
         out_dur_ff  <= dur_c;
         out_err_ff  <= serr_ff;
         out_end_ff  <= end_ff;
      end
   end

   assign st.need_div = emit_c || tempo_c;
   assign st.is_emit  = emit_ff;
   assign st.div_done = (cnt_ff == '0);
   assign st.div_busy = (cnt_ff != '0);

   assign rsp_semitone_index = out_idx_ff;
   assign rsp_frequency_hz   = out_freq_ff;
   assign rsp_duration_ms    = out_dur_ff;
   assign rsp_octave_error   = out_err_ff;
   assign rsp_end_of_tune    = out_end_ff;

endmodule
